// ===== design/rbv_pkg.sv =====
// shared types, constants and helper functions for the 2d body velocity step
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package rbv_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_BODY_MASS = 3'd0;
  localparam logic [2:0] CFG_FRICTION  = 3'd1;
  localparam logic [2:0] CFG_GRAVITY_X = 3'd2;
  localparam logic [2:0] CFG_GRAVITY_Y = 3'd3;
  localparam logic [2:0] CFG_SIDE_LIM  = 3'd4;
  localparam logic [2:0] CFG_FALL_LIM  = 3'd5;

  // configuration reset values
  localparam logic [30:0] RST_BODY_MASS = 31'd65536;
  localparam logic [30:0] RST_FRICTION  = 31'd655360;
  localparam logic [31:0] RST_GRAVITY_X = 32'd0;
  localparam logic [31:0] RST_GRAVITY_Y = 32'd52428800;
  localparam logic [30:0] RST_SIDE_LIM  = 31'd131072000;
  localparam logic [30:0] RST_FALL_LIM  = 31'd655360000;

  // saturation bounds
  localparam logic signed [63:0] SAT32_MIN = -64'sd2147483648;
  localparam logic signed [63:0] SAT32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT40_MIN = -64'sd549755813888;
  localparam logic signed [63:0] SAT40_MAX = 64'sd549755813887;

  // operations of the shared bit-serial unit
  typedef enum logic [1:0] {
    AR_MUL,
    AR_DIV,
    AR_SQRT
  } arith_op_t;

  // kind of work that one step does
  typedef enum logic [2:0] {
    K_LOCAL,
    K_NORM,
    K_MUL,
    K_DIV,
    K_SQRT
  } step_kind_t;

  // steps of one frame tick
  typedef enum logic [5:0] {
    ST_FX_MUL, ST_FX_DIV, ST_FY_MUL, ST_FY_DIV,
    ST_G_LOAD, ST_G_NORM, ST_G_SQX, ST_G_SQY, ST_G_SQRT, ST_G_DIVX, ST_G_DIVY,
    ST_DOT_X, ST_DOT_Y, ST_RM_X, ST_RM_Y, ST_AIR_X, ST_AIR_Y,
    ST_SDOT_X, ST_SDOT_Y, ST_SP_X, ST_SP_Y, ST_CLAMP_DOT, ST_AL_X, ST_AL_Y,
    ST_SLEN_SQX, ST_SLEN_SQY, ST_SLEN_SQRT, ST_SIDE_CHK,
    ST_CL_MX, ST_CL_DX, ST_CL_MY, ST_CL_DY, ST_COMB, ST_FR_CHK,
    ST_FR_M1, ST_FR_M2, ST_FLEN_SQX, ST_FLEN_SQY, ST_FLEN_SQRT, ST_STOP_CHK,
    ST_FR_ZERO, ST_FR_MX, ST_FR_DX, ST_FR_MY, ST_FR_DY, ST_PX, ST_PY
  } step_t;

  // controller states
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_ISSUE,
    CS_NORM,
    CS_WAIT,
    CS_PUBLISH
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    step_t step;
    logic  go;
    logic  wb;
    logic  load;
    logic  publish;
  } rbv_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic arith_done;
    logic norm_done;
    logic grav_zero;
    logic ground;
    logic side_over;
    logic vel_zero;
    logic fric_stop;
    logic out_free;
  } rbv_status_t;

  function automatic step_kind_t step_kind(input step_t s);
    step_kind_t k;
    case (s)
      ST_G_LOAD, ST_CLAMP_DOT, ST_SIDE_CHK, ST_COMB, ST_FR_CHK, ST_STOP_CHK,
      ST_FR_ZERO: k = K_LOCAL;
      ST_G_NORM: k = K_NORM;
      ST_FX_DIV, ST_FY_DIV, ST_G_DIVX, ST_G_DIVY, ST_CL_DX, ST_CL_DY,
      ST_FR_DX, ST_FR_DY: k = K_DIV;
      ST_G_SQRT, ST_SLEN_SQRT, ST_FLEN_SQRT: k = K_SQRT;
      default: k = K_MUL;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] with_sign(input logic [63:0] m, input logic neg);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] sat_s(input logic signed [63:0] v,
                                                input logic signed [63:0] lo,
                                                input logic signed [63:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    return sat_s(v, SAT32_MIN, SAT32_MAX);
  endfunction

endpackage
`default_nettype wire

// ===== design/rbv_arith.sv =====
// shared bit-serial unit: 64-bit multiply (low word), divide and floor square root
// depends on rbv_pkg
`timescale 1ns / 1ps
`default_nettype none
module rbv_arith (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire rbv_pkg::arith_op_t op,
  input  wire logic [63:0]       a,
  input  wire logic [63:0]       b,
  output logic [63:0]            result,
  output logic                   done
);
  import rbv_pkg::*;

  arith_op_t   op_r, op_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] y_r, y_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [64:0] div_t, sq_t, sq_trial;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    rem_r <= rem_nxt;
  end

  // one bit (one bit pair for the root) per cycle
  always_comb begin
    op_nxt   = op_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    rem_nxt  = rem_r;
    div_t    = {rem_r[63:0], x_r[63]};
    sq_t     = {rem_r[62:0], x_r[63:62]};
    sq_trial = {31'd0, acc_r[31:0], 2'b01};
    if (start) begin
      op_nxt   = op;
      busy_nxt = 1'b1;
      acc_nxt  = '0;
      rem_nxt  = '0;
      x_nxt    = a;
      y_nxt    = b;
      cnt_nxt  = (op == AR_SQRT) ? 6'd31 : 6'd63;
    end else if (busy_r) begin
      case (op_r)
        AR_MUL: begin
          if (y_r[0]) acc_nxt = acc_r + x_r;
          x_nxt = {x_r[62:0], 1'b0};
          y_nxt = {1'b0, y_r[63:1]};
        end
        AR_DIV: begin
          if (div_t >= {1'b0, y_r}) begin
            rem_nxt = div_t - {1'b0, y_r};
            x_nxt   = {x_r[62:0], 1'b1};
          end else begin
            rem_nxt = div_t;
            x_nxt   = {x_r[62:0], 1'b0};
          end
        end
        AR_SQRT: begin
          x_nxt = {x_r[61:0], 2'b00};
          if (sq_t >= sq_trial) begin
            rem_nxt = sq_t - sq_trial;
            acc_nxt = {32'd0, acc_r[30:0], 1'b1};
          end else begin
            rem_nxt = sq_t;
            acc_nxt = {32'd0, acc_r[30:0], 1'b0};
          end
        end
        default: ;
      endcase
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  assign result = (op_r == AR_DIV) ? x_r : acc_r;
  assign done   = done_r;

endmodule
`default_nettype wire

// ===== design/rbv_datapath.sv =====
// datapath: configuration, velocity state, working registers, output word
// depends on rbv_pkg and rbv_arith
`timescale 1ns / 1ps
`default_nettype none
module rbv_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rbv_pkg::rbv_cmd_t   cmd,
  output rbv_pkg::rbv_status_t     status,
  input  wire logic                cfg_wr_en,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire logic signed [31:0]  in_force_x,
  input  wire logic signed [31:0]  in_force_y,
  input  wire logic [15:0]         in_step_time,
  input  wire logic                in_on_ground,
  input  wire logic signed [39:0]  in_position_x,
  input  wire logic signed [39:0]  in_position_y,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output logic signed [39:0]       out_new_position_x,
  output logic signed [39:0]       out_new_position_y,
  output logic signed [31:0]       out_speed_x,
  output logic signed [31:0]       out_speed_y
);
  import rbv_pkg::*;

  // configuration
  logic [30:0]        mass_r, fric_r, side_lim_r, fall_lim_r;
  logic signed [31:0] gx_r, gy_r;
  // velocity state
  logic signed [31:0] vx_r, vx_nxt, vy_r, vy_nxt;
  // latched input word
  logic signed [31:0] fx_r, fx_nxt, fy_r, fy_nxt;
  logic [15:0]        dt_r, dt_nxt;
  logic               ground_r, ground_nxt;
  logic signed [39:0] px_r, px_nxt, py_r, py_nxt;
  // working registers
  logic signed [63:0] wx_r, wx_nxt, wy_r, wy_nxt;
  logic signed [63:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [63:0] dot_r, dot_nxt, acc_r, acc_nxt;
  logic [63:0]        len_r, len_nxt, famt_r, famt_nxt;
  logic signed [31:0] ux_r, ux_nxt, uy_r, uy_nxt;
  logic [31:0]        gmx_r, gmx_nxt, gmy_r, gmy_nxt;
  logic [2:0]         sh_r, sh_nxt;
  // output word
  logic               ov_r, ov_nxt;
  logic signed [39:0] onpx_r, onpx_nxt, onpy_r, onpy_nxt;
  logic signed [31:0] osx_r, osx_nxt, osy_r, osy_nxt;

  // arithmetic unit link
  step_kind_t         kind;
  logic               ar_start, ar_done;
  arith_op_t          ar_op;
  logic [63:0]        ar_a, ar_b, res;
  logic               sgn;
  logic signed [63:0] sres;
  logic [63:0]        divisor, fall_ext;
  // vector length prescale
  logic [63:0]        vma, vmb, vor, vsa, vsb;
  logic [2:0]         vsh;

  rbv_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ar_start),
    .op     (ar_op),
    .a      (ar_a),
    .b      (ar_b),
    .result (res),
    .done   (ar_done)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r     <= RST_BODY_MASS;
      fric_r     <= RST_FRICTION;
      gx_r       <= RST_GRAVITY_X;
      gy_r       <= RST_GRAVITY_Y;
      side_lim_r <= RST_SIDE_LIM;
      fall_lim_r <= RST_FALL_LIM;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BODY_MASS: mass_r     <= cfg_data[30:0];
        CFG_FRICTION:  fric_r     <= cfg_data[30:0];
        CFG_GRAVITY_X: gx_r       <= cfg_data;
        CFG_GRAVITY_Y: gy_r       <= cfg_data;
        CFG_SIDE_LIM:  side_lim_r <= cfg_data[30:0];
        CFG_FALL_LIM:  fall_lim_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // control state: velocity and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r <= '0;
      vy_r <= '0;
      ov_r <= 1'b0;
    end else begin
      vx_r <= vx_nxt;
      vy_r <= vy_nxt;
      ov_r <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fx_r     <= fx_nxt;
    fy_r     <= fy_nxt;
    dt_r     <= dt_nxt;
    ground_r <= ground_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    wx_r     <= wx_nxt;
    wy_r     <= wy_nxt;
    sx_r     <= sx_nxt;
    sy_r     <= sy_nxt;
    dot_r    <= dot_nxt;
    acc_r    <= acc_nxt;
    len_r    <= len_nxt;
    famt_r   <= famt_nxt;
    ux_r     <= ux_nxt;
    uy_r     <= uy_nxt;
    gmx_r    <= gmx_nxt;
    gmy_r    <= gmy_nxt;
    sh_r     <= sh_nxt;
    onpx_r   <= onpx_nxt;
    onpy_r   <= onpy_nxt;
    osx_r    <= osx_nxt;
    osy_r    <= osy_nxt;
  end

  // vector length prescale: bring both magnitudes below 2^31
  always_comb begin
    if (cmd.step == ST_SLEN_SQX || cmd.step == ST_SLEN_SQY) begin
      vma = mag64(sx_r);
      vmb = mag64(sy_r);
    end else begin
      vma = mag64(wx_r);
      vmb = mag64(wy_r);
    end
    vor = vma | vmb;
    vsh = 3'd7;
    for (int k = 7; k >= 0; k--) begin
      if ((vor >> k) < 64'h8000_0000) vsh = 3'(k);
    end
    vsa = vma >> vsh;
    vsb = vmb >> vsh;
  end

  // operand selection for the shared unit
  always_comb begin
    kind     = step_kind(cmd.step);
    divisor  = (mass_r == 31'd0) ? 64'd1 : 64'(mass_r);
    ar_start = cmd.go && (kind == K_MUL || kind == K_DIV || kind == K_SQRT);
    case (kind)
      K_DIV:   ar_op = AR_DIV;
      K_SQRT:  ar_op = AR_SQRT;
      default: ar_op = AR_MUL;
    endcase
    ar_a = acc_r;
    ar_b = 64'd0;
    case (cmd.step)
      ST_FX_MUL: begin ar_a = mag64(64'(fx_r)); ar_b = 64'(dt_r); end
      ST_FY_MUL: begin ar_a = mag64(64'(fy_r)); ar_b = 64'(dt_r); end
      ST_FX_DIV, ST_FY_DIV: begin ar_a = acc_r; ar_b = divisor; end
      ST_G_SQX: begin ar_a = 64'(gmx_r); ar_b = 64'(gmx_r); end
      ST_G_SQY: begin ar_a = 64'(gmy_r); ar_b = 64'(gmy_r); end
      ST_G_DIVX: begin ar_a = 64'(gmx_r) << 30; ar_b = len_r; end
      ST_G_DIVY: begin ar_a = 64'(gmy_r) << 30; ar_b = len_r; end
      ST_DOT_X, ST_SDOT_X: begin ar_a = mag64(wx_r); ar_b = mag64(64'(ux_r)); end
      ST_DOT_Y, ST_SDOT_Y: begin ar_a = mag64(wy_r); ar_b = mag64(64'(uy_r)); end
      ST_RM_X, ST_SP_X, ST_AL_X: begin ar_a = mag64(64'(ux_r)); ar_b = mag64(dot_r); end
      ST_RM_Y, ST_SP_Y, ST_AL_Y: begin ar_a = mag64(64'(uy_r)); ar_b = mag64(dot_r); end
      ST_AIR_X: begin ar_a = mag64(64'(gx_r)); ar_b = 64'(dt_r); end
      ST_AIR_Y: begin ar_a = mag64(64'(gy_r)); ar_b = 64'(dt_r); end
      ST_SLEN_SQX, ST_FLEN_SQX: begin ar_a = vsa; ar_b = vsa; end
      ST_SLEN_SQY, ST_FLEN_SQY: begin ar_a = vsb; ar_b = vsb; end
      ST_CL_MX: begin ar_a = mag64(sx_r); ar_b = 64'(side_lim_r); end
      ST_CL_MY: begin ar_a = mag64(sy_r); ar_b = 64'(side_lim_r); end
      ST_CL_DX, ST_CL_DY, ST_FR_DX, ST_FR_DY: begin ar_a = acc_r; ar_b = len_r; end
      ST_FR_M1: begin ar_a = 64'(fric_r); ar_b = 64'(mass_r); end
      ST_FR_M2: begin ar_a = 64'(acc_r >>> 16); ar_b = 64'(dt_r); end
      ST_FR_MX: begin ar_a = mag64(wx_r); ar_b = famt_r; end
      ST_FR_MY: begin ar_a = mag64(wy_r); ar_b = famt_r; end
      ST_PX: begin ar_a = mag64(wx_r); ar_b = 64'(dt_r); end
      ST_PY: begin ar_a = mag64(wy_r); ar_b = 64'(dt_r); end
      default: ;
    endcase
  end

  // sign of the unit result for the step being written back
  always_comb begin
    case (cmd.step)
      ST_FX_DIV:            sgn = fx_r[31];
      ST_FY_DIV:            sgn = fy_r[31];
      ST_G_DIVX:            sgn = gx_r[31];
      ST_G_DIVY:            sgn = gy_r[31];
      ST_DOT_X, ST_SDOT_X:  sgn = wx_r[63] ^ ux_r[31];
      ST_DOT_Y, ST_SDOT_Y:  sgn = wy_r[63] ^ uy_r[31];
      ST_RM_X, ST_SP_X, ST_AL_X: sgn = ux_r[31] ^ dot_r[63];
      ST_RM_Y, ST_SP_Y, ST_AL_Y: sgn = uy_r[31] ^ dot_r[63];
      ST_AIR_X:             sgn = gx_r[31];
      ST_AIR_Y:             sgn = gy_r[31];
      ST_CL_DX:             sgn = sx_r[63];
      ST_CL_DY:             sgn = sy_r[63];
      ST_FR_DX, ST_PX:      sgn = wx_r[63];
      ST_FR_DY, ST_PY:      sgn = wy_r[63];
      default:              sgn = 1'b0;
    endcase
    sres = with_sign(res, sgn);
  end

  // register updates
  always_comb begin
    fx_nxt = fx_r;  fy_nxt = fy_r;  dt_nxt = dt_r;  ground_nxt = ground_r;
    px_nxt = px_r;  py_nxt = py_r;
    wx_nxt = wx_r;  wy_nxt = wy_r;  sx_nxt = sx_r;  sy_nxt = sy_r;
    dot_nxt = dot_r;  acc_nxt = acc_r;  len_nxt = len_r;  famt_nxt = famt_r;
    ux_nxt = ux_r;  uy_nxt = uy_r;  gmx_nxt = gmx_r;  gmy_nxt = gmy_r;
    sh_nxt = sh_r;
    vx_nxt = vx_r;  vy_nxt = vy_r;
    ov_nxt = ov_r;
    onpx_nxt = onpx_r;  onpy_nxt = onpy_r;  osx_nxt = osx_r;  osy_nxt = osy_r;
    fall_ext = 64'(fall_lim_r);

    // take the input word, start from the kept velocity
    if (cmd.load) begin
      fx_nxt     = in_force_x;
      fy_nxt     = in_force_y;
      dt_nxt     = in_step_time;
      ground_nxt = in_on_ground;
      px_nxt     = in_position_x;
      py_nxt     = in_position_y;
      wx_nxt     = 64'(vx_r);
      wy_nxt     = 64'(vy_r);
    end

    // local steps, done without the shared unit
    if (cmd.go && kind == K_LOCAL) begin
      case (cmd.step)
        ST_G_LOAD: begin
          gmx_nxt = 32'(mag64(64'(gx_r)));
          gmy_nxt = 32'(mag64(64'(gy_r)));
          ux_nxt  = '0;
          uy_nxt  = '0;
        end
        ST_CLAMP_DOT: dot_nxt = sat_s(dot_r, -$signed(fall_ext), $signed(fall_ext));
        ST_COMB: begin
          wx_nxt = sat32(wx_r + sx_r);
          wy_nxt = sat32(wy_r + sy_r);
        end
        ST_FR_ZERO: begin
          wx_nxt = '0;
          wy_nxt = '0;
        end
        default: ;
      endcase
    end

    // gravity normalising shift
    if (cmd.go && kind == K_NORM && !status.norm_done) begin
      gmx_nxt = {gmx_r[30:0], 1'b0};
      gmy_nxt = {gmy_r[30:0], 1'b0};
    end

    // shared unit write-back
    if (cmd.wb) begin
      case (cmd.step)
        ST_FX_MUL, ST_FY_MUL, ST_G_SQX, ST_CL_MX, ST_CL_MY, ST_FR_M1, ST_FR_MX,
        ST_FR_MY: acc_nxt = $signed(res);
        ST_FX_DIV: wx_nxt = sat32(wx_r + sres);
        ST_FY_DIV: wy_nxt = sat32(wy_r + sres);
        ST_G_SQY, ST_SLEN_SQY, ST_FLEN_SQY: acc_nxt = acc_r + $signed(res);
        ST_G_SQRT: len_nxt = res;
        ST_G_DIVX: ux_nxt = 32'(sres);
        ST_G_DIVY: uy_nxt = 32'(sres);
        ST_DOT_X, ST_SDOT_X: acc_nxt = sres;
        ST_DOT_Y, ST_SDOT_Y: dot_nxt = (acc_r + sres) >>> 30;
        ST_RM_X: wx_nxt = sat32(wx_r - (sres >>> 30));
        ST_RM_Y: wy_nxt = sat32(wy_r - (sres >>> 30));
        ST_AIR_X: wx_nxt = sat32(wx_r + (sres >>> 16));
        ST_AIR_Y: wy_nxt = sat32(wy_r + (sres >>> 16));
        ST_SP_X: sx_nxt = wx_r - (sres >>> 30);
        ST_SP_Y: sy_nxt = wy_r - (sres >>> 30);
        ST_AL_X: wx_nxt = sres >>> 30;
        ST_AL_Y: wy_nxt = sres >>> 30;
        ST_SLEN_SQX, ST_FLEN_SQX: begin
          acc_nxt = $signed(res);
          sh_nxt  = vsh;
        end
        ST_SLEN_SQRT, ST_FLEN_SQRT: len_nxt = res << sh_r;
        ST_CL_DX: sx_nxt = sres;
        ST_CL_DY: sy_nxt = sres;
        ST_FR_M2: famt_nxt = res >> 16;
        ST_FR_DX: wx_nxt = wx_r - sres;
        ST_FR_DY: wy_nxt = wy_r - sres;
        ST_PX: px_nxt = 40'(sat_s(64'(px_r) + (sres >>> 16), SAT40_MIN, SAT40_MAX));
        ST_PY: py_nxt = 40'(sat_s(64'(py_r) + (sres >>> 16), SAT40_MIN, SAT40_MAX));
        default: ;
      endcase
    end

    // output word and velocity state
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (cmd.publish) begin
      ov_nxt   = 1'b1;
      onpx_nxt = px_r;
      onpy_nxt = py_r;
      osx_nxt  = 32'(wx_r);
      osy_nxt  = 32'(wy_r);
      vx_nxt   = 32'(wx_r);
      vy_nxt   = 32'(wy_r);
    end
  end

  // status towards the controller
  always_comb begin
    status.arith_done = ar_done;
    status.norm_done  = (gmx_r[31:30] != 2'b00) || (gmy_r[31:30] != 2'b00);
    status.grav_zero  = (gx_r == 32'sd0) && (gy_r == 32'sd0);
    status.ground     = ground_r;
    status.side_over  = 64'(side_lim_r) < len_r;
    status.vel_zero   = (wx_r == 64'sd0) && (wy_r == 64'sd0);
    status.fric_stop  = len_r <= famt_r;
    status.out_free   = !ov_r || !out_stall;
  end

  assign out_valid          = ov_r;
  assign out_new_position_x = onpx_r;
  assign out_new_position_y = onpy_r;
  assign out_speed_x        = osx_r;
  assign out_speed_y        = osy_r;

endmodule
`default_nettype wire

// ===== design/rbv_ctrl.sv =====
// controller: steps one frame tick through the datapath
// depends on rbv_pkg
`timescale 1ns / 1ps
`default_nettype none
module rbv_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire rbv_pkg::rbv_status_t status,
  output rbv_pkg::rbv_cmd_t         cmd
);
  import rbv_pkg::*;

  ctl_state_t state_r, state_nxt;
  step_t      step_r, step_nxt;
  step_t      step_after;

  // step sequence, branches on datapath status
  function automatic step_t next_step(input step_t s, input rbv_status_t st);
    step_t n;
    case (s)
      ST_FX_MUL:    n = ST_FX_DIV;
      ST_FX_DIV:    n = ST_FY_MUL;
      ST_FY_MUL:    n = ST_FY_DIV;
      ST_FY_DIV:    n = ST_G_LOAD;
      ST_G_LOAD:    n = st.grav_zero ? (st.ground ? ST_DOT_X : ST_AIR_X) : ST_G_NORM;
      ST_G_NORM:    n = ST_G_SQX;
      ST_G_SQX:     n = ST_G_SQY;
      ST_G_SQY:     n = ST_G_SQRT;
      ST_G_SQRT:    n = ST_G_DIVX;
      ST_G_DIVX:    n = ST_G_DIVY;
      ST_G_DIVY:    n = st.ground ? ST_DOT_X : ST_AIR_X;
      ST_DOT_X:     n = ST_DOT_Y;
      ST_DOT_Y:     n = ST_RM_X;
      ST_RM_X:      n = ST_RM_Y;
      ST_RM_Y:      n = ST_SDOT_X;
      ST_AIR_X:     n = ST_AIR_Y;
      ST_AIR_Y:     n = ST_SDOT_X;
      ST_SDOT_X:    n = ST_SDOT_Y;
      ST_SDOT_Y:    n = ST_SP_X;
      ST_SP_X:      n = ST_SP_Y;
      ST_SP_Y:      n = ST_CLAMP_DOT;
      ST_CLAMP_DOT: n = ST_AL_X;
      ST_AL_X:      n = ST_AL_Y;
      ST_AL_Y:      n = ST_SLEN_SQX;
      ST_SLEN_SQX:  n = ST_SLEN_SQY;
      ST_SLEN_SQY:  n = ST_SLEN_SQRT;
      ST_SLEN_SQRT: n = ST_SIDE_CHK;
      ST_SIDE_CHK:  n = st.side_over ? ST_CL_MX : ST_COMB;
      ST_CL_MX:     n = ST_CL_DX;
      ST_CL_DX:     n = ST_CL_MY;
      ST_CL_MY:     n = ST_CL_DY;
      ST_CL_DY:     n = ST_COMB;
      ST_COMB:      n = ST_FR_CHK;
      ST_FR_CHK:    n = st.vel_zero ? ST_PX : ST_FR_M1;
      ST_FR_M1:     n = ST_FR_M2;
      ST_FR_M2:     n = ST_FLEN_SQX;
      ST_FLEN_SQX:  n = ST_FLEN_SQY;
      ST_FLEN_SQY:  n = ST_FLEN_SQRT;
      ST_FLEN_SQRT: n = ST_STOP_CHK;
      ST_STOP_CHK:  n = st.fric_stop ? ST_FR_ZERO : ST_FR_MX;
      ST_FR_ZERO:   n = ST_PX;
      ST_FR_MX:     n = ST_FR_DX;
      ST_FR_DX:     n = ST_FR_MY;
      ST_FR_MY:     n = ST_FR_DY;
      ST_FR_DY:     n = ST_PX;
      ST_PX:        n = ST_PY;
      default:      n = ST_PY;
    endcase
    return n;
  endfunction

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      step_r  <= ST_FX_MUL;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    step_after  = next_step(step_r, status);
    in_stall    = 1'b1;
    cmd.step    = step_r;
    cmd.go      = 1'b0;
    cmd.wb      = 1'b0;
    cmd.load    = 1'b0;
    cmd.publish = 1'b0;
    case (state_r)
      CS_IDLE: begin
        // no word is taken while reset is held
        in_stall = !rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          step_nxt  = ST_FX_MUL;
          state_nxt = CS_ISSUE;
        end
      end
      CS_ISSUE: begin
        case (step_kind(step_r))
          K_LOCAL: begin
            cmd.go    = 1'b1;
            step_nxt  = step_after;
          end
          K_NORM:  state_nxt = CS_NORM;
          default: begin
            cmd.go    = 1'b1;
            state_nxt = CS_WAIT;
          end
        endcase
      end
      CS_NORM: begin
        if (status.norm_done) begin
          step_nxt  = step_after;
          state_nxt = CS_ISSUE;
        end else begin
          cmd.go = 1'b1;
        end
      end
      CS_WAIT: begin
        if (status.arith_done) begin
          cmd.wb = 1'b1;
          if (step_r == ST_PY) begin
            state_nxt = CS_PUBLISH;
          end else begin
            step_nxt  = step_after;
            state_nxt = CS_ISSUE;
          end
        end
      end
      CS_PUBLISH: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/rigid_body_velocity_step_2d.sv =====
// 2d body velocity step: one word per frame tick, one result word per input word.
// multiplies, divides and square roots run one at a time in the shared bit-serial unit;
// gravity is normalised by shifting before its length is taken.
// throughput: one word at a time; the next word is taken once the result is in the output
// register. reset (rst_n low, synchronous) restores the configuration defaults and zero velocity.
// depends on rbv_pkg, rbv_ctrl, rbv_datapath
`timescale 1ns / 1ps
`default_nettype none
module rigid_body_velocity_step_2d (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_force_x,
  input  wire logic signed [31:0] in_force_y,
  input  wire logic [15:0]        in_step_time,
  input  wire logic               in_on_ground,
  input  wire logic signed [39:0] in_position_x,
  input  wire logic signed [39:0] in_position_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [39:0]      out_new_position_x,
  output logic signed [39:0]      out_new_position_y,
  output logic signed [31:0]      out_speed_x,
  output logic signed [31:0]      out_speed_y
);
  import rbv_pkg::*;

  rbv_cmd_t    cmd;
  rbv_status_t status;

  // sequencer
  rbv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and storage
  rbv_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_force_x         (in_force_x),
    .in_force_y         (in_force_y),
    .in_step_time       (in_step_time),
    .in_on_ground       (in_on_ground),
    .in_position_x      (in_position_x),
    .in_position_y      (in_position_y),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_new_position_x (out_new_position_x),
    .out_new_position_y (out_new_position_y),
    .out_speed_x        (out_speed_x),
    .out_speed_y        (out_speed_y)
  );

endmodule
`default_nettype wire

// ===== dv/tb_rigid_body_velocity_step_2d.sv =====
// self-checking testbench for rigid_body_velocity_step_2d: a directed table, then random frame
// ticks under several configurations, checked against typed words or a body-motion predictor
// depends on rbv_pkg and the rigid_body_velocity_step_2d rtl
`timescale 1ns / 1ps
module tb_rigid_body_velocity_step_2d;
  import rbv_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 3000;
  localparam int ITEMS_PER_SET  = 85;
  localparam longint POS_MAX    = 64'sd549755813887;
  localparam longint POS_MIN    = -64'sd549755813888;

  typedef struct {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic [15:0]        dt;
    logic               grounded;
    logic signed [39:0] pos_x;
    logic signed [39:0] pos_y;
  } tick_t;

  typedef struct {
    logic signed [39:0] pos_x;
    logic signed [39:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } motion_t;

  typedef struct {
    tick_t   tick;
    bit      typed;
    motion_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_force_x = '0;
  logic signed [31:0] in_force_y = '0;
  logic [15:0] in_step_time = '0;
  logic in_on_ground = 1'b0;
  logic signed [39:0] in_position_x = '0;
  logic signed [39:0] in_position_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [39:0] out_new_position_x;
  logic signed [39:0] out_new_position_y;
  logic signed [31:0] out_speed_x;
  logic signed [31:0] out_speed_y;

  // body state and register copies held by the predictor
  longint body_vx, body_vy;
  logic [31:0] reg_copy [6];

  motion_t motion_q[$];
  row_t directed[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  rigid_body_velocity_step_2d dut (.*);

  always #5 clk = ~clk;

  // fixed-point helpers
  function automatic longint unsigned magn(input longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint signed_as(input longint unsigned m, input longint ref_v);
    return ref_v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint clip32(input longint v);
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned res = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned vec_len(input longint a, input longint b);
    longint unsigned ma = magn(a);
    longint unsigned mb = magn(b);
    int r = 0;
    while ((ma | mb) >= 64'h8000_0000) begin
      ma >>= 1;
      mb >>= 1;
      r++;
    end
    return floor_sqrt(ma * ma + mb * mb) << r;
  endfunction

  // one frame tick of the body: updates the kept velocity, returns the new motion
  function automatic motion_t advance_body(input tick_t t);
    longint mass = longint'(reg_copy[CFG_BODY_MASS][30:0]);
    longint fric = longint'(reg_copy[CFG_FRICTION][30:0]);
    longint gx = longint'($signed(reg_copy[CFG_GRAVITY_X]));
    longint gy = longint'($signed(reg_copy[CFG_GRAVITY_Y]));
    longint unsigned side_lim = 64'(reg_copy[CFG_SIDE_LIM][30:0]);
    longint fall_lim = longint'(reg_copy[CFG_FALL_LIM][30:0]);
    longint dt = longint'(t.dt);
    longint divisor, vx, vy, ux, uy, dot, ax, ay, sx, sy;
    longint unsigned mx, my, len, famt;
    motion_t m;
    divisor = (mass == 0) ? 64'sd1 : mass;
    vx = clip32(body_vx + (longint'(t.force_x) * dt) / divisor);
    vy = clip32(body_vy + (longint'(t.force_y) * dt) / divisor);
    // unit gravity in q2.30
    ux = 0;
    uy = 0;
    mx = magn(gx);
    my = magn(gy);
    if ((mx | my) != 0) begin
      while ((mx | my) < 64'h4000_0000) begin
        mx <<= 1;
        my <<= 1;
      end
      len = floor_sqrt(mx * mx + my * my);
      ux = signed_as((mx << 30) / len, gx);
      uy = signed_as((my << 30) / len, gy);
    end
    if (t.grounded) begin
      dot = (vx * ux + vy * uy) >>> 30;
      vx = clip32(vx - ((ux * dot) >>> 30));
      vy = clip32(vy - ((uy * dot) >>> 30));
    end else begin
      vx = clip32(vx + ((gx * dt) >>> 16));
      vy = clip32(vy + ((gy * dt) >>> 16));
    end
    // split along and across gravity, clamp each part
    dot = (vx * ux + vy * uy) >>> 30;
    sx = vx - ((ux * dot) >>> 30);
    sy = vy - ((uy * dot) >>> 30);
    dot = clip(dot, -fall_lim, fall_lim);
    ax = (ux * dot) >>> 30;
    ay = (uy * dot) >>> 30;
    len = vec_len(sx, sy);
    if (side_lim < len) begin
      sx = signed_as(magn(sx) * side_lim / len, sx);
      sy = signed_as(magn(sy) * side_lim / len, sy);
    end
    vx = clip32(ax + sx);
    vy = clip32(ay + sy);
    // kinetic friction against the motion
    if (vx != 0 || vy != 0) begin
      famt = longint'(((fric * mass) >>> 16) * dt) >> 16;
      len = vec_len(vx, vy);
      if (len <= famt) begin
        vx = 0;
        vy = 0;
      end else begin
        vx -= signed_as(magn(vx) * famt / len, vx);
        vy -= signed_as(magn(vy) * famt / len, vy);
      end
    end
    body_vx = vx;
    body_vy = vy;
    m.pos_x = 40'(clip(longint'(t.pos_x) + ((vx * dt) >>> 16), POS_MIN, POS_MAX));
    m.pos_y = 40'(clip(longint'(t.pos_y) + ((vy * dt) >>> 16), POS_MIN, POS_MAX));
    m.vel_x = 32'(vx);
    m.vel_y = 32'(vy);
    return m;
  endfunction

  task automatic report_mismatch(input string field, input longint want, input longint got);
    $display("mismatch %s: expected %0d got %0d at %0t", field, want, got, $realtime);
    errors++;
  endtask

  // result word check
  always @(posedge clk) begin
    motion_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (motion_q.size() == 0) begin
        report_mismatch("pending words", 0, 1);
      end else begin
        w = motion_q.pop_front();
        if (out_new_position_x !== w.pos_x)
          report_mismatch("new_position_x", w.pos_x, out_new_position_x);
        if (out_new_position_y !== w.pos_y)
          report_mismatch("new_position_y", w.pos_y, out_new_position_y);
        if (out_speed_x !== w.vel_x) report_mismatch("speed_x", w.vel_x, out_speed_x);
        if (out_speed_y !== w.vel_y) report_mismatch("speed_y", w.vel_y, out_speed_y);
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_rigid_body_velocity_step_2d: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one register write, enable left high for a following write
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    reg_copy[idx] = (idx == CFG_GRAVITY_X || idx == CFG_GRAVITY_Y) ? value : {1'b0, value[30:0]};
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [31:0] v [6]);
    for (int i = 0; i < 6; i++) write_reg(3'(i), v[i]);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // hand one tick over and predict it once accepted
  task automatic send_tick(input tick_t t, input bit typed, input motion_t want);
    motion_t m;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_force_x <= t.force_x;
    in_force_y <= t.force_y;
    in_step_time <= t.dt;
    in_on_ground <= t.grounded;
    in_position_x <= t.pos_x;
    in_position_y <= t.pos_y;
    do @(posedge clk); while (!(in_valid && !in_stall));
    m = advance_body(t);
    motion_q.push_back(typed ? want : m);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (motion_q.size() != 0);
  endtask

  function automatic logic [31:0] rand_signed_scalar();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return 32'($signed($urandom_range(131072)) - 65536);
      default: return 32'($signed($urandom_range(200000)) - 100000) <<< 8;
    endcase
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    t.force_x = rand_signed_scalar();
    t.force_y = rand_signed_scalar();
    case ($urandom_range(3))
      0: t.dt = 16'($urandom);
      1: t.dt = 16'd1092;
      default: t.dt = 16'($urandom_range(4000));
    endcase
    t.grounded = 1'($urandom_range(1));
    case ($urandom_range(5))
      0: t.pos_x = 40'(POS_MAX);
      1: t.pos_x = 40'(POS_MIN);
      default: t.pos_x = 40'({$urandom, $urandom});
    endcase
    t.pos_y = 40'({$urandom, $urandom});
    return t;
  endfunction

  function automatic row_t mk_row(input longint fx, input longint fy, input int dt,
                                  input bit gnd, input longint px, input longint py,
                                  input bit typed);
    row_t r;
    r.tick.force_x = 32'(fx);
    r.tick.force_y = 32'(fy);
    r.tick.dt = 16'(dt);
    r.tick.grounded = gnd;
    r.tick.pos_x = 40'(px);
    r.tick.pos_y = 40'(py);
    r.typed = typed;
    // at rest with zero frame time nothing moves
    r.want.pos_x = 40'(px);
    r.want.pos_y = 40'(py);
    r.want.vel_x = '0;
    r.want.vel_y = '0;
    return r;
  endfunction

  initial begin
    logic [31:0] regs [6];
    motion_t none;
    none = '{default: '0};
    body_vx = 0;
    body_vy = 0;
    reg_copy[CFG_BODY_MASS] = 32'(RST_BODY_MASS);
    reg_copy[CFG_FRICTION] = 32'(RST_FRICTION);
    reg_copy[CFG_GRAVITY_X] = RST_GRAVITY_X;
    reg_copy[CFG_GRAVITY_Y] = RST_GRAVITY_Y;
    reg_copy[CFG_SIDE_LIM] = 32'(RST_SIDE_LIM);
    reg_copy[CFG_FALL_LIM] = 32'(RST_FALL_LIM);

    // directed table: rest rows typed, the rest predicted
    directed.push_back(mk_row(0, 0, 0, 0, 0, 0, 1));
    directed.push_back(mk_row(0, 0, 0, 0, POS_MAX, POS_MIN, 1));
    directed.push_back(mk_row(0, 0, 0, 1, POS_MIN, POS_MAX, 1));
    directed.push_back(mk_row(32'sh7FFF_FFFF, -32'sh8000_0000, 0, 0, -1, 1, 1));
    directed.push_back(mk_row(0, 0, 65535, 0, 0, 0, 0));
    directed.push_back(mk_row(0, 0, 1092, 1, 0, 0, 0));
    directed.push_back(mk_row(32'sh7FFF_FFFF, -32'sh8000_0000, 65535, 0, 0, 0, 0));
    directed.push_back(mk_row(-32'sh8000_0000, 32'sh7FFF_FFFF, 65535, 1, 0, 0, 0));
    directed.push_back(mk_row(0, 0, 65535, 1, 0, 0, 0));
    // small push on the ground that friction stops
    directed.push_back(mk_row(65536, 0, 1092, 1, 100, 100, 0));
    directed.push_back(mk_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 65535, 0, POS_MAX, POS_MAX, 0));
    directed.push_back(mk_row(-32'sh8000_0000, -32'sh8000_0000, 65535, 0, POS_MIN, POS_MIN, 0));
    directed.push_back(mk_row(1, 1, 1, 0, 1, -1, 0));
    directed.push_back(mk_row(-1, -1, 65535, 1, -1, -1, 0));
    directed.push_back(mk_row(-32'sh6400000, 0, 1092, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_tick(directed[i].tick, directed[i].typed, directed[i].want);
    wait_drained();

    // random sets: extremes, random, zero mass, back to defaults
    for (int set_no = 0; set_no < 6; set_no++) begin
      case (set_no)
        0: regs = '{32'd1, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        1: regs = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0};
        3: regs = '{32'd0, $urandom_range(1 << 20), rand_signed_scalar(),
                    rand_signed_scalar(), $urandom, $urandom};
        5: regs = '{32'(RST_BODY_MASS), 32'(RST_FRICTION), RST_GRAVITY_X, RST_GRAVITY_Y,
                    32'(RST_SIDE_LIM), 32'(RST_FALL_LIM)};
        default: regs = '{$urandom_range(1, 1 << 20), $urandom_range(1 << 20),
                          rand_signed_scalar(), rand_signed_scalar(),
                          $urandom_range(1 << 28), $urandom_range(1 << 29)};
      endcase
      case (set_no / 2)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      load_regs(regs);
      for (int n = 0; n < ITEMS_PER_SET; n++) send_tick(rand_tick(), 0, none);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_rigid_body_velocity_step_2d: PASS");
    end else begin
      $display("tb_rigid_body_velocity_step_2d: FAIL");
    end
    $finish;
  end

endmodule
